// ===== hw/rtl/actsel_pkg.sv =====
`default_nettype none
package actsel_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 16;

    // One stored activity
    typedef struct packed {
        logic [ID_W-1:0]   act_id;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
    } act_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_FLUSH
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/actsel_store.sv =====
`default_nettype none
module actsel_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire actsel_pkg::act_t  wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output actsel_pkg::act_t       rd_data
);
    import actsel_pkg::*;

    act_t mem [DEPTH];
    act_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/activity_selection.sv =====
// A non-final item is written to the store while it has room; busy stays low.
// After the final item of a set of n stored activities, selection runs n rounds, each a
// full pass over the stored activities (one read per cycle) followed by a pick state,
// then a flush state emits the last result; busy stays high until the flush is done.
// Results pulse out_valid for one cycle each; the receiver cannot stall.
// Reset clears the count and the sequencer; memory contents are not cleared.
`default_nettype none
module activity_selection #(
    parameter int MAX_ACTIVITIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [actsel_pkg::ID_W-1:0]   act_id,
    input  wire logic [actsel_pkg::TIME_W-1:0] start_time,
    input  wire logic [actsel_pkg::TIME_W-1:0] end_time,
    input  wire logic                          last_item,
    output logic                               out_valid,
    output logic [actsel_pkg::ID_W-1:0]        out_id,
    output logic [actsel_pkg::TIME_W-1:0]      out_start,
    output logic [actsel_pkg::TIME_W-1:0]      out_end,
    output logic                               out_last
);
    import actsel_pkg::*;

    localparam int IW = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
    localparam int CW = $clog2(MAX_ACTIVITIES + 1);
    localparam int KW = TIME_W + IW;

    state_t state_reg, state_next;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     addr_reg;
    logic [CW-1:0]     round_reg;
    logic              rd_en_reg;
    logic              rd_last_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              have_prev_reg;
    logic [KW-1:0]     prev_key_reg;
    logic              best_found_reg;
    logic [KW-1:0]     best_key_reg;
    act_t              best_reg;
    act_t              pend_reg;
    logic [TIME_W-1:0] last_end_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    act_t              out_reg;

    act_t          wr_data;
    act_t          rd_data;
    logic [KW-1:0] cand_key;
    logic          accept;
    logic          wr_en;
    logic          issue;
    logic          qual;
    logic          better;
    logic          take;
    logic          pick_done;
    logic          emit_mid;
    logic          emit_final;

    assign wr_data = '{act_id: act_id, t_start: start_time, t_end: end_time};

    actsel_store #(
        .DEPTH (MAX_ACTIVITIES),
        .AW    (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (addr_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    // Stable order by end time: key is end time, then arrival index
    assign cand_key  = {rd_data.t_end, rd_idx_reg};
    assign qual      = !have_prev_reg || (cand_key > prev_key_reg);
    assign better    = !best_found_reg || (cand_key < best_key_reg);
    assign pick_done = (round_reg == CW'(n_reg - CW'(1)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && last_item)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en_reg && rd_last_reg)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                state_next = pick_done ? S_FLUSH : S_SCAN;
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        accept     = 1'b0;
        issue      = 1'b0;
        take       = 1'b0;
        emit_final = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                accept = start;
            end
            S_SCAN:
            begin
                issue = (addr_reg < n_reg);
            end
            S_PICK:
            begin
                take = !have_prev_reg || (best_reg.t_start > last_end_reg);
            end
            S_FLUSH:
            begin
                emit_final = 1'b1;
            end
            default:
            begin
                accept = 1'b0;
            end
        endcase
    end

    assign wr_en    = accept && (count_reg < CW'(MAX_ACTIVITIES));
    assign emit_mid = take && have_prev_reg;
    assign busy     = (state_reg != S_IDLE);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            n_reg          <= '0;
            addr_reg       <= '0;
            round_reg      <= '0;
            rd_en_reg      <= 1'b0;
            rd_last_reg    <= 1'b0;
            have_prev_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            last_end_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_en_reg     <= issue;
            rd_last_reg   <= (addr_reg == CW'(n_reg - CW'(1)));
            out_valid_reg <= emit_mid || emit_final;
            out_last_reg  <= emit_final;

            // Store one activity; the final one closes the set
            if (accept)
            begin
                if (last_item)
                begin
                    n_reg          <= wr_en ? CW'(count_reg + CW'(1)) : count_reg;
                    count_reg      <= '0;
                    addr_reg       <= '0;
                    round_reg      <= '0;
                    have_prev_reg  <= 1'b0;
                    best_found_reg <= 1'b0;
                end
                else if (wr_en)
                begin
                    count_reg <= CW'(count_reg + CW'(1));
                end
            end

            if (issue)
            begin
                addr_reg <= CW'(addr_reg + CW'(1));
            end

            if (rd_en_reg && qual && better)
            begin
                best_found_reg <= 1'b1;
            end

            // End of a pass: the minimum becomes the new lower bound
            if (state_reg == S_PICK)
            begin
                have_prev_reg  <= 1'b1;
                best_found_reg <= 1'b0;
                addr_reg       <= '0;
                round_reg      <= CW'(round_reg + CW'(1));
                if (take)
                begin
                    last_end_reg <= best_reg.t_end;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rd_en_reg && qual && better)
        begin
            best_key_reg <= cand_key;
            best_reg     <= rd_data;
        end
        if (issue)
        begin
            rd_idx_reg <= addr_reg[IW-1:0];
        end
        if (state_reg == S_PICK)
        begin
            prev_key_reg <= best_key_reg;
            if (take)
            begin
                pend_reg <= best_reg;
            end
        end
        if (emit_mid || emit_final)
        begin
            out_reg <= pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_id    = out_reg.act_id;
    assign out_start = out_reg.t_start;
    assign out_end   = out_reg.t_end;

endmodule
`default_nettype wire

// ===== tb/activity_selection_test.sv =====
`default_nettype none
module activity_selection_test;

    import actsel_pkg::*;

    localparam int MAX_ACTS     = 16;
    localparam int CYCLE_LIMIT  = 200000;
    // one complete selection for a full store, plus margin
    localparam int DRAIN_CYCLES = MAX_ACTS * (MAX_ACTS + 2) + 16;
    localparam int RANDOM_ITEMS = 96;

    // One expected selection
    typedef struct {
        act_t act;
        bit   last;
    } pick_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ID_W-1:0]     act_id;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   end_time;
    logic                last_item;
    logic                out_valid;
    logic [ID_W-1:0]     out_id;
    logic [TIME_W-1:0]   out_start;
    logic [TIME_W-1:0]   out_end;
    logic                out_last;

    // Predictor state: activities held for the open set, and picks still owed
    act_t                held_acts[$];
    logic [TIME_W-1:0]   last_taken_end;
    pick_t               pending_picks[$];

    int                  mismatches;
    int                  items_sent;
    int                  sets_closed;
    int                  picks_checked;
    int                  cycle_count;
    bit                  no_gaps;

    activity_selection #(
        .MAX_ACTIVITIES (MAX_ACTS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .act_id     (act_id),
        .start_time (start_time),
        .end_time   (end_time),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_id     (out_id),
        .out_start  (out_start),
        .out_end    (out_end),
        .out_last   (out_last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d picks still owed", $time, pending_picks.size());
            $display("activity_selection regression: fail");
            $finish;
        end
    end

    // Close the open set: stable sort by end time, then greedy scan
    task automatic close_activity_set();
        act_t  sorted_acts[$];
        act_t  cur;
        pick_t picks[$];
        pick_t rec;
        int    j;
        sorted_acts = held_acts;
        held_acts.delete();
        if (sorted_acts.size() == 0)
            return;
        for (int i = 1; i < sorted_acts.size(); i++)
        begin
            cur = sorted_acts[i];
            j = i;
            while (j > 0 && sorted_acts[j-1].t_end > cur.t_end)
            begin
                sorted_acts[j] = sorted_acts[j-1];
                j--;
            end
            sorted_acts[j] = cur;
        end
        // first activity is always taken
        rec.act  = sorted_acts[0];
        rec.last = 1'b0;
        picks.push_back(rec);
        last_taken_end = sorted_acts[0].t_end;
        for (int i = 1; i < sorted_acts.size(); i++)
        begin
            if (sorted_acts[i].t_start > last_taken_end)
            begin
                rec.act = sorted_acts[i];
                picks.push_back(rec);
                last_taken_end = sorted_acts[i].t_end;
            end
        end
        picks[picks.size()-1].last = 1'b1;
        foreach (picks[k])
            pending_picks.push_back(picks[k]);
        sets_closed++;
    endtask

    // Predictor update for one accepted transaction
    task automatic record_activity(input act_t a, input bit last);
        // store full: the item is dropped, a last item still closes the set
        if (held_acts.size() < MAX_ACTS)
            held_acts.push_back(a);
        if (last)
            close_activity_set();
    endtask

    // Drive one activity; called at a falling edge, returns at a falling edge
    task automatic send_activity(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t_s,
                                 input logic [TIME_W-1:0] t_e, input bit last);
        int   gap;
        act_t a;
        gap = no_gaps ? 0 : int'($urandom_range(0, 10));
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        act_id     = id;
        start_time = t_s;
        end_time   = t_e;
        last_item  = last;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy);
        a.act_id  = id;
        a.t_start = t_s;
        a.t_end   = t_e;
        record_activity(a, last);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        pick_t exp_pick;
        if (rst_n && out_valid)
        begin
            if (pending_picks.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual id %0h start %0h end %0h",
                         $time, out_id, out_start, out_end);
                mismatches++;
            end
            else
            begin
                exp_pick = pending_picks.pop_front();
                check_field("out_id", int'(exp_pick.act.act_id), int'(out_id));
                check_field("out_start", int'(exp_pick.act.t_start), int'(out_start));
                check_field("out_end", int'(exp_pick.act.t_end), int'(out_end));
                check_field("out_last", int'(exp_pick.last), int'(out_last));
                picks_checked++;
            end
        end
    end

    // Sets of one activity at the field extremes
    task automatic test_single_activity();
        send_activity(8'h00, 16'h0000, 16'h0000, 1'b1);
        send_activity(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    // Equal end times keep arrival order; start equal to last end is rejected
    task automatic test_ties_and_bounds();
        send_activity(8'h11, 16'd0, 16'd10, 1'b0);
        send_activity(8'h12, 16'd20, 16'd10, 1'b1);
        send_activity(8'h21, 16'd20, 16'd10, 1'b0);
        send_activity(8'h22, 16'd0, 16'd10, 1'b1);
        send_activity(8'h31, 16'd5, 16'd9, 1'b0);
        send_activity(8'h32, 16'd9, 16'd12, 1'b0);
        send_activity(8'h33, 16'd10, 16'd15, 1'b1);
    endtask

    // Seventeen items: the last one falls beyond capacity but still closes the set
    task automatic test_store_overflow();
        no_gaps = 1'b1;
        for (int i = 0; i < MAX_ACTS; i++)
            send_activity(8'(8'h80 + i), 16'(3 * i), 16'(3 * i + 2 + (i % 3)), 1'b0);
        send_activity(8'hEE, 16'hFFF0, 16'hFFFE, 1'b1);
        no_gaps = 1'b0;
    endtask

    // Random sets, mostly small with dense time windows
    task automatic test_random_sets();
        int                set_size;
        int                sent_before;
        bit                wide_times;
        logic [TIME_W-1:0] t_s;
        logic [TIME_W-1:0] t_e;
        sent_before = items_sent;
        while (items_sent - sent_before < RANDOM_ITEMS)
        begin
            set_size   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(MAX_ACTS, MAX_ACTS + 4))
                                                     : int'($urandom_range(1, 6));
            wide_times = ($urandom_range(0, 3) == 0);
            no_gaps    = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_size; i++)
            begin
                if (wide_times)
                begin
                    t_s = 16'($urandom_range(0, 16'hFFFF));
                    t_e = 16'($urandom_range(0, 16'hFFFF));
                end
                else
                begin
                    t_s = 16'($urandom_range(0, 40));
                    t_e = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 40))
                                                      : 16'(t_s + $urandom_range(0, 12));
                end
                send_activity(8'($urandom_range(0, 255)), t_s, t_e, i == set_size - 1);
            end
        end
        no_gaps = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        act_id         = '0;
        start_time     = '0;
        end_time       = '0;
        last_item      = 1'b0;
        last_taken_end = '0;
        mismatches     = 0;
        items_sent     = 0;
        sets_closed    = 0;
        picks_checked  = 0;
        cycle_count    = 0;
        no_gaps        = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_activity();
        test_ties_and_bounds();
        test_store_overflow();
        test_random_sets();
        start = 1'b0;

        // let the last selection drain, then watch for stray results
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d activities in %0d sets, %0d selected activities checked.",
                 items_sent, sets_closed, picks_checked);
        $display("Sets included single items, end-time ties, overflow past %0d entries.",
                 MAX_ACTS);
        if (mismatches == 0)
            $display("activity_selection regression: pass");
        else
            $display("activity_selection regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
